/* sv/svf_pkg.sv */
// ---------------------------------------------------------------------------
// svf_pkg - shared types, constants and microcode for the state variable filter
// Arithmetic widths, rounding and saturation helpers, and the control store
// that sequences one sample through the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package svf_pkg;

   // Sample and integrator widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int GUARD_BITS   = 8;
   localparam int ACC_WIDTH    = SAMPLE_WIDTH + GUARD_BITS;
   localparam int COEFF_BITS   = 16;
   localparam int MODE_BITS    = 3;
   localparam int CSR_IDX_BITS = 2;

   // Product of a zero-extended coefficient and an integrator value
   localparam int PROD_W = COEFF_BITS + 1 + ACC_WIDTH;
   // Product after the rounding shift
   localparam int RND_W  = PROD_W - COEFF_BITS;
   // Headroom for up to two adds ahead of saturation
   localparam int SUM_W  = ACC_WIDTH + 3;

   localparam int STEP_BITS = 3;

   typedef logic [STEP_BITS-1:0] step_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FREQ  = 2'd0,
      CSR_DAMP  = 2'd1,
      CSR_MODE  = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   // Output select codes; anything above MODE_NOTCH mutes
   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOW   = 3'd0,
      MODE_BAND  = 3'd1,
      MODE_HIGH  = 3'd2,
      MODE_NOTCH = 3'd3,
      MODE_MUTE  = 3'd4
   } mode_type;

   // Multiplier operand selects
   typedef enum logic {
      COEF_FREQ = 1'b0,
      COEF_DAMP = 1'b1
   } coef_sel_type;

   typedef enum logic [1:0] {
      OPB_BAND   = 2'd0,
      OPB_SAMPLE = 2'd1,
      OPB_HIGH   = 2'd2,
      OPB_ZERO   = 2'd3
   } opb_sel_type;

   // Adder / writeback operation of a step
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOW   = 3'd1,
      OP_DIFF  = 3'd2,
      OP_HIGH  = 3'd3,
      OP_NOTCH = 3'd4,
      OP_BAND  = 3'd5,
      OP_OUT   = 3'd6
   } acc_op_type;

   // One microcode word
   typedef struct packed {
      logic         wait_in;   // hold here until a sample transfer
      logic         wait_out;  // hold here until the output register is free
      logic         mul_en;    // load the product register
      coef_sel_type coef_sel;
      opb_sel_type  opb_sel;
      acc_op_type   acc_op;
      step_type     next;
   } ctrl_word_type;

   // Step addresses
   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_MFB   = 3'd1;
   localparam step_type STEP_LOW   = 3'd2;
   localparam step_type STEP_DIFF  = 3'd3;
   localparam step_type STEP_HIGH  = 3'd4;
   localparam step_type STEP_MFH   = 3'd5;
   localparam step_type STEP_BAND  = 3'd6;
   localparam step_type STEP_OUT   = 3'd7;

   // Control store
   function automatic ctrl_word_type ucode(input step_type addr);
      ctrl_word_type w;
      w = '{wait_in: 1'b0, wait_out: 1'b0, mul_en: 1'b0, coef_sel: COEF_FREQ,
            opb_sel: OPB_ZERO, acc_op: OP_NONE, next: STEP_IDLE};
      unique case (addr)
         // wait for a sample
         STEP_IDLE: begin
            w.wait_in = 1'b1;
            w.next    = STEP_MFB;
         end
         // f * band
         STEP_MFB: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_FREQ;
            w.opb_sel  = OPB_BAND;
            w.next     = STEP_LOW;
         end
         // low += rnd(f * band); start Q * x
         STEP_LOW: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_DAMP;
            w.opb_sel  = OPB_SAMPLE;
            w.acc_op   = OP_LOW;
            w.next     = STEP_DIFF;
         end
         // diff = rnd(Q * x) - low; start Q * band
         STEP_DIFF: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_DAMP;
            w.opb_sel  = OPB_BAND;
            w.acc_op   = OP_DIFF;
            w.next     = STEP_HIGH;
         end
         // high = sat(diff - rnd(Q * band))
         STEP_HIGH: begin
            w.acc_op = OP_HIGH;
            w.next   = STEP_MFH;
         end
         // f * high; notch = sat(high + low)
         STEP_MFH: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_FREQ;
            w.opb_sel  = OPB_HIGH;
            w.acc_op   = OP_NOTCH;
            w.next     = STEP_BAND;
         end
         // band += rnd(f * high)
         STEP_BAND: begin
            w.acc_op = OP_BAND;
            w.next   = STEP_OUT;
         end
         // load the output register
         STEP_OUT: begin
            w.wait_out = 1'b1;
            w.acc_op   = OP_OUT;
            w.next     = STEP_IDLE;
         end
         default: begin
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // floor((p + 2^15) / 2^16): round half up
   function automatic logic signed [RND_W-1:0] round_prod(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(1 << (COEFF_BITS - 1));
      return t[PROD_W-1:COEFF_BITS];
   endfunction

   // Clamp a sum to the signed integrator range
   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[ACC_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[ACC_WIDTH-1:0];
      end
      return v[ACC_WIDTH-1:0];
   endfunction

   // Clamp an integrator value to the signed sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
      input logic signed [ACC_WIDTH-1:0] v
   );
      logic signed [ACC_WIDTH-1:0] hi;
      logic signed [ACC_WIDTH-1:0] lo;
      hi = {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_WIDTH-1:0];
      end
      return v[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* sv/state_variable_filter.sv */
// ---------------------------------------------------------------------------
// state_variable_filter - two-pole state variable filter, microcoded
// One shared 17x24 multiplier is sequenced by a small control store to
// update the low-pass and band-pass integrators, then one node is picked.
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------
//  req      | in  | req_tvalid/req_tready | req_tdata[15:0]  sample_in
//  rsp      | out | rsp_tvalid/rsp_tready | rsp_tdata[15:0]  sample_out
//  csr      | in  | csr_valid/csr_ready   | csr_index, csr_data (register write)
//
//  Each sample passes through one idle step plus seven microcode steps,
//  a count set by the four products that go one after another through
//  the single multiplier.
//  The result sits in an output register, so the next sample is taken
//  while it waits; the sequencer only stalls in its last step if that
//  register is still full. Synchronous reset returns only the integrators,
//  sequencer, settings and valid flag to defaults. csr writes are always taken.
//
`default_nettype none

module state_variable_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample in
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [svf_pkg::SAMPLE_WIDTH-1:0]  req_tdata,   // [15:0] sample_in
   // sample out
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [svf_pkg::SAMPLE_WIDTH-1:0]  rsp_tdata,   // [15:0] sample_out
   // register writes
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [svf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [svf_pkg::COEFF_BITS-1:0]    csr_data
);
   import svf_pkg::*;

   // Registers
   step_type                        step_ff, step_in;
   logic [COEFF_BITS-1:0]           freq_ff, freq_in;
   logic [COEFF_BITS-1:0]           damp_ff, damp_in;
   logic [MODE_BITS-1:0]            mode_ff, mode_in;
   logic signed [SAMPLE_WIDTH-1:0]  x_ff, x_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]     low_ff, low_in;
   logic signed [ACC_WIDTH-1:0]     band_ff, band_in;
   logic signed [ACC_WIDTH-1:0]     high_ff, high_in;
   logic signed [ACC_WIDTH-1:0]     notch_ff, notch_in;
   logic signed [SUM_W-1:0]         diff_ff, diff_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]         rsp_data_ff, rsp_data_in;

   ctrl_word_type                   cw;
   logic                            req_xfer;
   logic                            out_busy;
   logic                            advance;
   logic                            out_load;
   logic signed [COEFF_BITS:0]      mul_a;
   logic signed [ACC_WIDTH-1:0]     mul_b;
   logic signed [RND_W-1:0]         rnd_val;
   logic signed [ACC_WIDTH-1:0]     sel_node;

   // Control word fetch and step sequencing
   assign cw         = ucode(step_ff);
   assign req_tready = cw.wait_in;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   always_comb begin
      advance = 1'b1;
      if (cw.wait_in && !req_tvalid) begin
         advance = 1'b0;
      end
      if (cw.wait_out && out_busy) begin
         advance = 1'b0;
      end
      step_in = advance ? cw.next : step_ff;
   end

   assign out_load = advance && (cw.acc_op == OP_OUT);

   // Register file writes
   assign csr_ready = 1'b1;
   always_comb begin
      freq_in = freq_ff;
      damp_in = damp_ff;
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FREQ: freq_in = csr_data;
            CSR_DAMP: damp_in = csr_data;
            CSR_MODE: mode_in = csr_data[MODE_BITS-1:0];
            default:  ;
         endcase
      end
   end

   // Shared multiplier operands and product register
   always_comb begin
      mul_a = (cw.coef_sel == COEF_DAMP) ? $signed({1'b0, damp_ff})
                                         : $signed({1'b0, freq_ff});
      unique case (cw.opb_sel)
         OPB_BAND:   mul_b = band_ff;
         OPB_SAMPLE: mul_b = ACC_WIDTH'(x_ff);
         OPB_HIGH:   mul_b = high_ff;
         default:    mul_b = '0;
      endcase
      prod_in = cw.mul_en ? PROD_W'(mul_a) * PROD_W'(mul_b) : prod_ff;
   end

   assign rnd_val = round_prod(prod_ff);
   assign x_in    = req_xfer ? $signed(req_tdata) : x_ff;

   // Adder / saturation stage driven by the step's operation
   always_comb begin
      low_in   = low_ff;
      band_in  = band_ff;
      high_in  = high_ff;
      notch_in = notch_ff;
      diff_in  = diff_ff;
      unique case (cw.acc_op)
         OP_LOW:   low_in   = sat_acc(SUM_W'(low_ff) + SUM_W'(rnd_val));
         OP_DIFF:  diff_in  = SUM_W'(rnd_val) - SUM_W'(low_ff);
         OP_HIGH:  high_in  = sat_acc(diff_ff - SUM_W'(rnd_val));
         OP_NOTCH: notch_in = sat_acc(SUM_W'(high_ff) + SUM_W'(low_ff));
         OP_BAND:  band_in  = sat_acc(SUM_W'(band_ff) + SUM_W'(rnd_val));
         default:  ;
      endcase
   end

   // Output select and output register
   always_comb begin
      unique case (mode_ff)
         MODE_LOW:   sel_node = low_ff;
         MODE_BAND:  sel_node = band_ff;
         MODE_HIGH:  sel_node = high_ff;
         MODE_NOTCH: sel_node = notch_ff;
         default:    sel_node = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sat_out(sel_node);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         freq_ff      <= '1;
         damp_ff      <= '1;
         mode_ff      <= MODE_LOW;
         low_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         freq_ff      <= freq_in;
         damp_ff      <= damp_in;
         mode_ff      <= mode_in;
         low_ff       <= low_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      high_ff     <= high_in;
      notch_ff    <= notch_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_xfer_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> step_ff == STEP_MFB)
      else $error("sample transfer did not start the sequence");

   a_load_at_out: assert property (@(posedge clock) disable iff (reset)
      out_load |-> step_ff == STEP_OUT && !out_busy)
      else $error("output register loaded outside the output step or while full");

   a_mute_zero: assert property (@(posedge clock) disable iff (reset)
      out_load && mode_ff != MODE_LOW && mode_ff != MODE_BAND &&
      mode_ff != MODE_HIGH && mode_ff != MODE_NOTCH |=> rsp_data_ff == '0)
      else $error("muted output is not zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* tb/state_variable_filter_tb.sv */
// ---------------------------------------------------------------------------
// state_variable_filter_tb - self-checking testbench for the filter
// Streams audio samples through the block and checks every output sample
// against a cycle-free model of the two integrators, across many register
// settings, random idle cycles on both streams and a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module state_variable_filter_tb;

   import svf_pkg::*;

   localparam int ITEM_CYCLES     = 8;    // one sample through the sequencer
   localparam int DRAIN_CYCLES    = 2 * ITEM_CYCLES;
   localparam int RANDOM_PHASES   = 16;
   localparam int PHASE_SAMPLES   = 100;
   localparam int PRESSURE_SAMPLES = 40;
   localparam int HOLD_CYCLES     = 100;
   localparam int CLEAN_SAMPLES   = 200;
   localparam logic [MODE_BITS-1:0] MODE_LAST = '1;

   typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_QUIET} wave_kind_type;

   // DUT ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_WIDTH-1:0] req_tdata = '0;     // [15:0] sample_in
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [SAMPLE_WIDTH-1:0] rsp_tdata;          // [15:0] sample_out
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_idx_type             csr_index = CSR_FREQ;
   logic [COEFF_BITS-1:0]   csr_data = '0;

   // Filter model: registers and integrators at their reset values
   logic [COEFF_BITS-1:0]          freq_reg = '1;
   logic [COEFF_BITS-1:0]          damp_reg = '1;
   logic [MODE_BITS-1:0]           mode_reg = MODE_LOW;
   logic signed [ACC_WIDTH-1:0]    lowpass_state = '0;
   logic signed [ACC_WIDTH-1:0]    bandpass_state = '0;

   logic [SAMPLE_WIDTH-1:0] expected_samples[$];
   int                      failures = 0;

   // Idle control
   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;
   int rsp_hold_cycles = 0;
   int rsp_gap_cycles  = 0;

   state_variable_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model arithmetic
   // ------------------------------------------------------------------------

   // coeff * v, rounded half up back to the scale of v
   function automatic longint coeff_scale(input logic [COEFF_BITS-1:0] coeff,
                                          input longint v);
      return (longint'(coeff) * v + (longint'(1) << (COEFF_BITS - 1))) >>> COEFF_BITS;
   endfunction

   function automatic longint clamp_signed(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // Advance both integrators by one sample and return the selected node
   function automatic logic [SAMPLE_WIDTH-1:0] filter_sample(
      input logic [SAMPLE_WIDTH-1:0] sample
   );
      longint x;
      longint low;
      longint band;
      longint high;
      longint notch;
      longint node;
      x    = longint'(signed'(sample));
      band = longint'(bandpass_state);
      low  = clamp_signed(longint'(lowpass_state) + coeff_scale(freq_reg, band), ACC_WIDTH);
      high = clamp_signed(coeff_scale(damp_reg, x) - low - coeff_scale(damp_reg, band),
                          ACC_WIDTH);
      band  = clamp_signed(band + coeff_scale(freq_reg, high), ACC_WIDTH);
      notch = clamp_signed(high + low, ACC_WIDTH);
      lowpass_state  = ACC_WIDTH'(low);
      bandpass_state = ACC_WIDTH'(band);
      case (mode_reg)
         MODE_LOW:   node = low;
         MODE_BAND:  node = band;
         MODE_HIGH:  node = high;
         MODE_NOTCH: node = notch;
         default:    node = 0;     // mute and every code above it
      endcase
      return SAMPLE_WIDTH'(clamp_signed(node, SAMPLE_WIDTH));
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // One sample transfer, with an optional idle burst ahead of it
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] sample);
      int gap;
      gap = (sender_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(filter_sample(sample));
   endtask

   // Stop offering samples and wait until every output has come back
   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   // One register write transfer; csr_valid stays up for a following write
   task automatic write_csr(input csr_idx_type index, input logic [COEFF_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FREQ: freq_reg = value;
         CSR_DAMP: damp_reg = value;
         CSR_MODE: mode_reg = value[MODE_BITS-1:0];
         default: ;        // unused index, dropped
      endcase
   endtask

   // Full register setting, applied only once the block is idle
   task automatic configure(input logic [COEFF_BITS-1:0] freq,
                            input logic [COEFF_BITS-1:0] damp,
                            input logic [COEFF_BITS-1:0] mode_word);
      wait_idle();
      write_csr(CSR_FREQ, freq);
      write_csr(CSR_DAMP, damp);
      write_csr(CSR_NONE, COEFF_BITS'($urandom));
      write_csr(CSR_MODE, mode_word);
      csr_valid <= 1'b0;
   endtask

   // Coefficient with a strong bias toward zero, one, half scale and full scale
   function automatic logic [COEFF_BITS-1:0] pick_coeff;
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return COEFF_BITS'(1);
         3:       return COEFF_BITS'(1) << (COEFF_BITS - 1);
         default: return COEFF_BITS'($urandom);
      endcase
   endfunction

   // Mode word with random junk above the mode bits
   function automatic logic [COEFF_BITS-1:0] mode_word_of(input logic [MODE_BITS-1:0] mode);
      return {(COEFF_BITS - MODE_BITS)'($urandom), mode};
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset setting, full-scale and near-zero samples
   task automatic test_sample_extremes;
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
      send_sample(16'sh0001);
      send_sample(16'sh7FFF);
   endtask

   // Every output select, including the codes past mute
   task automatic test_output_modes;
      for (int m = MODE_LOW; m <= MODE_LAST; m++) begin
         configure('1, COEFF_BITS'(1) << (COEFF_BITS - 2), mode_word_of(MODE_BITS'(m)));
         send_sample(16'sh7FFF);
         send_sample(16'sh8000);
      end
   endtask

   // Zero and full-scale coefficients
   task automatic test_coeff_extremes;
      configure('0, '0, mode_word_of(MODE_LOW));
      send_sample(16'sh8000);
      configure('0, '1, mode_word_of(MODE_BAND));
      send_sample(16'sh7FFF);
      configure('1, '0, mode_word_of(MODE_NOTCH));
      send_sample(16'sh0001);
   endtask

   // Random settings, each with its own waveform
   task automatic test_random_settings;
      wave_kind_type           wave;
      int                      period;
      int                      amp;
      logic [SAMPLE_WIDTH-1:0] x;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure(pick_coeff(), pick_coeff(), mode_word_of(MODE_BITS'($urandom)));
         wave   = wave_kind_type'($urandom_range(0, 2));
         period = $urandom_range(2, 40);
         amp    = $urandom_range(1, 32767);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            case (wave)
               WAVE_NOISE:  x = SAMPLE_WIDTH'($urandom);
               WAVE_SQUARE: x = ((n / period) % 2) ? SAMPLE_WIDTH'(-amp - 1)
                                                   : SAMPLE_WIDTH'(amp);
               default:     x = SAMPLE_WIDTH'($urandom_range(0, 511) - 256);
            endcase
            send_sample(x);
         end
      end
   endtask

   // Output held off long enough that the block stops taking samples
   task automatic test_output_backpressure;
      configure(pick_coeff(), pick_coeff(), mode_word_of(MODE_BITS'($urandom)));
      rsp_hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < PRESSURE_SAMPLES; n++) begin
         send_sample(SAMPLE_WIDTH'($urandom));
      end
   endtask

   // No idle bursts on either stream, so samples go in as fast as the block takes them
   task automatic test_full_rate;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      configure(pick_coeff(), pick_coeff(), mode_word_of(MODE_BITS'($urandom)));
      for (int n = 0; n < CLEAN_SAMPLES; n++) begin
         send_sample(SAMPLE_WIDTH'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Output side
   // ------------------------------------------------------------------------

   // Receiver ready: long hold on request, else random idle bursts
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_tready      <= 1'b0;
      end else if (rsp_gap_cycles > 0) begin
         rsp_gap_cycles <= rsp_gap_cycles - 1;
         rsp_tready     <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         rsp_gap_cycles <= $urandom_range(0, 3);
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each output transfer against the oldest predicted sample
   always @(posedge clock) begin : check_output
      logic [SAMPLE_WIDTH-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: no sample expected, actual %0d", signed'(rsp_tdata));
            failures++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want) begin
               $error("sample_out: expected %0d, actual %0d",
                      signed'(want), signed'(rsp_tdata));
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_sample_extremes();
      test_output_modes();
      test_coeff_extremes();
      test_random_settings();
      test_output_backpressure();
      test_full_rate();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: ends a run that hangs
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
